// ===== rtl/assert_macros.svh =====
// assertion macros used by point_rotate_about_pivot
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define PRAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define PRAP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/prap_pkg.sv =====
// types and constants of the pivot rotation pipeline
package prap_pkg;

  localparam int COORD_BITS      = 32;
  localparam int ANGLE_BITS      = 16;
  localparam int ROTATION_STEPS  = 16;
  localparam int TURN_BITS       = 32;
  localparam int SC_BITS         = 32;
  localparam int SC_FRAC         = 30;
  localparam int DIFF_BITS       = COORD_BITS + 1;
  localparam int PROD_BITS       = SC_BITS + DIFF_BITS;
  localparam int SUM_BITS        = PROD_BITS + 1;
  localparam int RND_BITS        = SUM_BITS - SC_FRAC;
  localparam int RES_BITS        = RND_BITS + 1;
  localparam int ATAN_ENTRIES    = 24;
  localparam int ATAN_IDX_BITS   = $clog2(ATAN_ENTRIES);
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = ROTATION_STEPS / STEPS_PER_STAGE;

  // pipeline stage positions
  localparam int ST_PREP    = 0;
  localparam int ST_CORDIC0 = 1;
  localparam int ST_QUAD    = CORDIC_STAGES + 1;
  localparam int ST_MUL     = ST_QUAD + 1;
  localparam int ST_SUM     = ST_MUL + 1;
  localparam int ST_OUT     = ST_SUM + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic signed [SC_BITS-1:0]  KINV_Q30  = SC_BITS'(652032874);
  localparam logic signed [SUM_BITS-1:0] ROUND_SUM = SUM_BITS'(1) <<< (SC_FRAC - 1);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [TURN_BITS-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [SC_BITS-1:0]   x;
    logic signed [SC_BITS-1:0]   y;
    logic signed [TURN_BITS-1:0] z;
    quad_e                       quad;
  } cordic_t;

  // per-request data that rides along with the rotation
  typedef struct packed {
    axis_e                        axis;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [COORD_BITS-1:0] pt_z;
    logic signed [COORD_BITS-1:0] pa;
    logic signed [COORD_BITS-1:0] pb;
    logic signed [DIFF_BITS-1:0]  da;
    logic signed [DIFF_BITS-1:0]  db;
  } side_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] val;
    logic                         clip;
  } sat_t;

endpackage

// ===== rtl/point_rotate_about_pivot.sv =====
// rotation of a point about an x, y or z axis through a pivot, fully pipelined; AXIS_NONE passes the point through
// 13 register stages: prep, the cordic stages, quadrant, multiply, sum and output
// throughput: one request per cycle while the output is not stalled; 8 cordic stages of two micro-rotations each
// stalls hold each stage in place; empty stages keep filling while the output waits
// reset (rst_ni low, asynchronous) clears all stage valid bits; data registers are not reset
`include "assert_macros.svh"

module point_rotate_about_pivot import prap_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] pivot_x_i,
  input  logic signed [COORD_BITS-1:0] pivot_y_i,
  input  logic signed [COORD_BITS-1:0] pivot_z_i,
  input  logic [ANGLE_BITS-1:0]        angle_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] new_x_o,
  output logic signed [COORD_BITS-1:0] new_y_o,
  output logic signed [COORD_BITS-1:0] new_z_o,
  output logic                         clipped_o
);

  logic [NUM_STAGES-1:0] v_q, v_d, adv;

  side_t   side_q [ST_SUM+1];
  side_t   side_d;
  cordic_t cor_q  [CORDIC_STAGES+1];
  cordic_t cor_d;

  logic signed [SC_BITS-1:0]   c_q, s_q, c_d, s_d;
  logic signed [PROD_BITS-1:0] p_cda_q, p_sdb_q, p_sda_q, p_cdb_q;
  logic signed [PROD_BITS-1:0] p_cda_d, p_sdb_d, p_sda_d, p_cdb_d;
  logic signed [SUM_BITS-1:0]  sum_a_q, sum_b_q, sum_a_d, sum_b_d;
  logic signed [COORD_BITS-1:0] new_x_q, new_y_q, new_z_q, new_x_d, new_y_d, new_z_d;
  logic                         clip_q, clip_d;

  function automatic cordic_t cordic_step(input cordic_t st, input logic [ATAN_IDX_BITS-1:0] idx);
    cordic_t r;
    logic signed [SC_BITS-1:0] xs, ys;
    xs = $signed(st.x) >>> idx;
    ys = $signed(st.y) >>> idx;
    r  = st;
    if (!st.z[TURN_BITS-1]) begin
      r.x = $signed(st.x) - ys;
      r.y = $signed(st.y) + xs;
      r.z = $signed(st.z) - ATAN_TURN[idx];
    end else begin
      r.x = $signed(st.x) + ys;
      r.y = $signed(st.y) - xs;
      r.z = $signed(st.z) + ATAN_TURN[idx];
    end
    return r;
  endfunction

  function automatic sat_t saturate(input logic signed [RES_BITS-1:0] v);
    sat_t r;
    logic hi_same;
    hi_same = (v[RES_BITS-1:COORD_BITS-1] == {(RES_BITS-COORD_BITS+1){v[RES_BITS-1]}});
    r.clip  = !hi_same;
    if (hi_same) begin
      r.val = v[COORD_BITS-1:0];
    end else if (v[RES_BITS-1]) begin
      r.val = COORD_MIN;
    end else begin
      r.val = COORD_MAX;
    end
    return r;
  endfunction

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    v_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  // prep: pick the rotated pair, form differences, fold the angle into a quadrant
  always_comb begin
    logic [TURN_BITS-1:0] turn;
    logic signed [COORD_BITS-1:0] a, b;
    turn = {angle_i, {(TURN_BITS-ANGLE_BITS){1'b0}}};
    side_d.axis = axis_e'(op_i);
    side_d.pt_x = point_x_i;
    side_d.pt_y = point_y_i;
    side_d.pt_z = point_z_i;
    case (axis_e'(op_i))
      AXIS_X: begin
        a = point_y_i; b = point_z_i; side_d.pa = pivot_y_i; side_d.pb = pivot_z_i;
      end
      AXIS_Y: begin
        a = point_z_i; b = point_x_i; side_d.pa = pivot_z_i; side_d.pb = pivot_x_i;
      end
      default: begin
        a = point_x_i; b = point_y_i; side_d.pa = pivot_x_i; side_d.pb = pivot_y_i;
      end
    endcase
    side_d.da = DIFF_BITS'(a) - DIFF_BITS'(side_d.pa);
    side_d.db = DIFF_BITS'(b) - DIFF_BITS'(side_d.pb);
    // residual of 1/8 turn or more wraps into the next quadrant
    cor_d.x    = KINV_Q30;
    cor_d.y    = '0;
    cor_d.z    = TURN_BITS'($signed(turn[TURN_BITS-3:0]));
    cor_d.quad = quad_e'(turn[TURN_BITS-1:TURN_BITS-2] + {1'b0, turn[TURN_BITS-3]});
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_PREP]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k <= ST_SUM; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_PREP]) begin
      cor_q[0] <= cor_d;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    cordic_t step_d;
    always_comb begin
      step_d = cor_q[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        step_d = cordic_step(step_d, ATAN_IDX_BITS'(g * STEPS_PER_STAGE + j));
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[ST_CORDIC0+g]) begin
        cor_q[g+1] <= step_d;
      end
    end
  end

  // quadrant applied exactly by swap and negate
  always_comb begin
    case (cor_q[CORDIC_STAGES].quad)
      QUAD_0: begin
        c_d = cor_q[CORDIC_STAGES].x;  s_d = cor_q[CORDIC_STAGES].y;
      end
      QUAD_90: begin
        c_d = -cor_q[CORDIC_STAGES].y; s_d = cor_q[CORDIC_STAGES].x;
      end
      QUAD_180: begin
        c_d = -cor_q[CORDIC_STAGES].x; s_d = -cor_q[CORDIC_STAGES].y;
      end
      default: begin
        c_d = cor_q[CORDIC_STAGES].y;  s_d = -cor_q[CORDIC_STAGES].x;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_QUAD]) begin
      c_q <= c_d;
      s_q <= s_d;
    end
  end

  always_comb begin
    p_cda_d = PROD_BITS'(c_q) * PROD_BITS'($signed(side_q[ST_QUAD].da));
    p_sdb_d = PROD_BITS'(s_q) * PROD_BITS'($signed(side_q[ST_QUAD].db));
    p_sda_d = PROD_BITS'(s_q) * PROD_BITS'($signed(side_q[ST_QUAD].da));
    p_cdb_d = PROD_BITS'(c_q) * PROD_BITS'($signed(side_q[ST_QUAD].db));
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_MUL]) begin
      p_cda_q <= p_cda_d;
      p_sdb_q <= p_sdb_d;
      p_sda_q <= p_sda_d;
      p_cdb_q <= p_cdb_d;
    end
  end

  // round to nearest, ties up
  always_comb begin
    sum_a_d = SUM_BITS'(p_cda_q) - SUM_BITS'(p_sdb_q) + ROUND_SUM;
    sum_b_d = SUM_BITS'(p_sda_q) + SUM_BITS'(p_cdb_q) + ROUND_SUM;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SUM]) begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  always_comb begin
    logic signed [RES_BITS-1:0] res_a, res_b;
    sat_t  sat_a, sat_b;
    side_t sd;
    sd    = side_q[ST_SUM];
    res_a = RES_BITS'($signed(sum_a_q[SUM_BITS-1:SC_FRAC])) + RES_BITS'($signed(sd.pa));
    res_b = RES_BITS'($signed(sum_b_q[SUM_BITS-1:SC_FRAC])) + RES_BITS'($signed(sd.pb));
    sat_a = saturate(res_a);
    sat_b = saturate(res_b);
    new_x_d = sd.pt_x;
    new_y_d = sd.pt_y;
    new_z_d = sd.pt_z;
    clip_d  = 1'b0;
    case (sd.axis)
      AXIS_X: begin
        new_y_d = sat_a.val; new_z_d = sat_b.val; clip_d = sat_a.clip || sat_b.clip;
      end
      AXIS_Y: begin
        new_z_d = sat_a.val; new_x_d = sat_b.val; clip_d = sat_a.clip || sat_b.clip;
      end
      AXIS_Z: begin
        new_x_d = sat_a.val; new_y_d = sat_b.val; clip_d = sat_a.clip || sat_b.clip;
      end
      default: begin
        clip_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      new_x_q <= new_x_d;
      new_y_q <= new_y_d;
      new_z_q <= new_z_d;
      clip_q  <= clip_d;
    end
  end

  assign in_ready_o  = adv[ST_PREP];
  assign out_valid_o = v_q[ST_OUT];
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign new_z_o     = new_z_q;
  assign clipped_o   = clip_q;

  `PRAP_ASSERT(a_empty_out_ready, !out_valid_o |-> in_ready_o, "pipeline refused a request with an empty output")
  `PRAP_ASSERT(a_accept_loads, (in_valid_i && in_ready_o) |=> v_q[ST_PREP], "accepted request did not enter the first stage")
  `PRAP_ASSERT(a_clip_at_bound, (out_valid_o && clipped_o) |-> ((new_x_o == COORD_MAX) || (new_x_o == COORD_MIN) || (new_y_o == COORD_MAX) || (new_y_o == COORD_MIN) || (new_z_o == COORD_MAX) || (new_z_o == COORD_MIN)), "clip flag without a saturated coordinate")
  `PRAP_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule
